>>> src/damped_spring_mass_gravity_step_unit_assert.svh
// Assertion macros for the damped spring-mass step unit.
// Needs clk and arst_n in the scope of the including module.
`ifndef DAMPED_SPRING_MASS_GRAVITY_STEP_UNIT_ASSERT_SVH
`define DAMPED_SPRING_MASS_GRAVITY_STEP_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DSM_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define DSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DSM_ASSERT_HOLDS(label, cond, msg)
`define DSM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> src/dsm_pkg.sv
// Shared types, constants and saturation helpers of the spring-mass step unit.
// Depends on nothing; used by the top level.
package dsm_pkg;
	localparam int DEF_FRAC_BITS = 16;
	localparam int NUM_REGS = 7;
	localparam int ADDR_W = 5;
	localparam logic [32:0] RECIP_SIXTY = 33'h088888889;
	localparam int SIXTY_SHIFT = 37;

	localparam logic [2:0] REG_ANCHOR_X = 3'd0;
	localparam logic [2:0] REG_ANCHOR_Y = 3'd1;
	localparam logic [2:0] REG_ANCHOR_Z = 3'd2;
	localparam logic [2:0] REG_REST = 3'd3;
	localparam logic [2:0] REG_SPRING = 3'd4;
	localparam logic [2:0] REG_DAMPING = 3'd5;
	localparam logic [2:0] REG_MASS = 3'd6;

	localparam logic signed [31:0] RST_ANCHOR_X = 32'sd0;
	localparam logic signed [31:0] RST_ANCHOR_Y = 32'sd65536;
	localparam logic signed [31:0] RST_ANCHOR_Z = 32'sd0;
	localparam logic [30:0] RST_REST = 31'd45875;
	localparam logic [30:0] RST_SPRING = 31'd6553600;
	localparam logic [30:0] RST_DAMPING = 31'd131072;
	localparam logic [30:0] RST_MASS = 31'd131072;

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_SQ, S_SQACC, S_SQRT, S_MOFF, S_DOFF, S_DIV, S_DISP,
		S_MK, S_FS, S_MC, S_FD, S_ACC, S_VEL, S_VELW, S_POS, S_POSW, S_FIN
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sd2147483647) return 32'sh7fffffff;
		if (v < -65'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic ovf32(input logic signed [64:0] v);
		return (v > 65'sd2147483647) || (v < -65'sd2147483648);
	endfunction
endpackage

>>> src/dsm_if.sv
// Request and result channel interfaces of the spring-mass step unit.
// Depends on nothing.
interface dsm_item_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic signed [31:0] start_z;
	modport source(output valid, func, start_x, start_y, start_z, input ready);
	modport sink(input valid, func, start_x, start_y, start_z, output ready);
endinterface

interface dsm_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic moving;
	logic saturated;
	modport source(output valid, pos_x, pos_y, pos_z, moving, saturated, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, moving, saturated, output ready);
endinterface

>>> src/damped_spring_mass_gravity_step_unit.sv
// Damped spring-mass step unit: one semi-implicit Euler tick (dt 1/60) per request, with a
// ball hung from a configurable anchor under gravity, coordinates signed fixed point and
// coefficients unsigned. A request occupies the block from the accepting cycle to the one in
// which its result is registered, running a 32-step square root and the shared 64-step
// restoring divider, used twice per axis. When the ball sits on the anchor the
// acceleration is kept, and a request that arrives before the first restart skips the tick.
// The block accepts the next request while a finished result still waits to be taken, and
// holds that request's result until the output register is free.
`include "damped_spring_mass_gravity_step_unit_assert.svh"
module damped_spring_mass_gravity_step_unit
	import dsm_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	dsm_item_if.sink           item,
	dsm_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam logic signed [63:0] GRAVITY =
		64'((98 * (64'sd1 <<< FRAC_BITS) + 5) / 10);

	state_t state_q, state_d, ret_q;

	logic signed [31:0] anc_q [3];
	logic [30:0] rest_q, spring_q, damp_q, mass_q;

	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic signed [31:0] acc_q [3];
	logic signed [31:0] d_q [3];
	logic running_q, sat_q;
	logic [1:0] i_q;
	logic signed [31:0] disp_q;
	logic signed [63:0] f_q, prod_q;
	logic [63:0] sum_q, x_q;
	logic [33:0] srem_q;
	logic [31:0] root_q;
	logic [5:0] cnt_q;
	logic [63:0] dn_q;
	logic [31:0] drem_q, dden_q;
	logic dneg_q;
	logic rv_q;

	logic wr_en;
	logic [2:0] reg_idx;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [63:0] prod_tr, quot, q60;
	logic [35:0] srem_n, strial;
	logic [32:0] drem_n;
	logic dbit;
	logic div_start;
	logic signed [63:0] div_num;
	logic [31:0] div_den;
	logic signed [64:0] diff_v, disp_v, force_v, vnew_v, pnew_v;
	logic signed [31:0] f32;
	logic out_free;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_ANCHOR_X: prdata = anc_q[0];
			REG_ANCHOR_Y: prdata = anc_q[1];
			REG_ANCHOR_Z: prdata = anc_q[2];
			REG_REST:     prdata = {1'b0, rest_q};
			REG_SPRING:   prdata = {1'b0, spring_q};
			REG_DAMPING:  prdata = {1'b0, damp_q};
			REG_MASS:     prdata = {1'b0, mass_q};
			default:      prdata = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign prod_tr = prod_q[63] ? -((-prod_q) >>> FRAC_BITS) : (prod_q >>> FRAC_BITS);
	assign quot = dneg_q ? -$signed(dn_q) : $signed(dn_q);
	assign q60 = dneg_q ? -(prod_q >>> SIXTY_SHIFT) : (prod_q >>> SIXTY_SHIFT);

	assign srem_n = {srem_q, x_q[63:62]};
	assign strial = {2'b00, root_q, 2'b01};
	assign drem_n = {drem_q, dn_q[63]};
	assign dbit = drem_n >= {1'b0, dden_q};

	assign diff_v = 65'(pos_q[i_q]) - 65'(anc_q[i_q]);
	assign disp_v = 65'(d_q[i_q]) - 65'(quot);
	assign force_v = 65'(f_q) - 65'(prod_tr) - ((i_q == 2'd1) ? 65'(GRAVITY) : 65'sd0);
	assign f32 = sat32(force_v);
	assign vnew_v = 65'(vel_q[i_q]) + 65'(q60);
	assign pnew_v = 65'(pos_q[i_q]) + 65'(q60);
	assign out_free = !rv_q || result.ready;

	always_comb begin
		state_d = state_q;
		item.ready = 1'b0;
		mul_a = 33'(d_q[i_q]);
		mul_b = 33'(d_q[i_q]);
		div_start = 1'b0;
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) state_d = (item.func || running_q) ? S_DIFF : S_FIN;
			end
			S_DIFF: if (i_q == 2'd2) state_d = S_SQ;
			S_SQ: state_d = S_SQACC;
			S_SQACC: state_d = (i_q == 2'd2) ? S_SQRT : S_SQ;
			S_SQRT: begin
				if (cnt_q == 6'd31) begin
					state_d = ({root_q[30:0], srem_n >= strial} == 32'd0) ? S_VEL : S_MOFF;
				end
			end
			S_MOFF: begin
				mul_b = {2'b00, rest_q};
				state_d = S_DOFF;
			end
			S_DOFF: begin
				div_start = 1'b1;
				div_num = prod_q;
				div_den = root_q;
				state_d = S_DIV;
			end
			S_DIV: if (cnt_q == 6'd63) state_d = ret_q;
			S_DISP: state_d = S_MK;
			S_MK: begin
				mul_a = 33'(disp_q);
				mul_b = {2'b00, spring_q};
				state_d = S_FS;
			end
			S_FS: state_d = S_MC;
			S_MC: begin
				mul_a = 33'(vel_q[i_q]);
				mul_b = {2'b00, damp_q};
				state_d = S_FD;
			end
			S_FD: begin
				div_start = 1'b1;
				div_num = 64'(f32) <<< FRAC_BITS;
				div_den = (mass_q == '0) ? 32'd1 : {1'b0, mass_q};
				state_d = S_DIV;
			end
			S_ACC: state_d = (i_q == 2'd2) ? S_VEL : S_MOFF;
			S_VEL: begin
				mul_a = acc_q[i_q][31] ? -33'(acc_q[i_q]) : 33'(acc_q[i_q]);
				mul_b = RECIP_SIXTY;
				state_d = S_VELW;
			end
			S_VELW: state_d = (i_q == 2'd2) ? S_POS : S_VEL;
			S_POS: begin
				mul_a = vel_q[i_q][31] ? -33'(vel_q[i_q]) : 33'(vel_q[i_q]);
				mul_b = RECIP_SIXTY;
				state_d = S_POSW;
			end
			S_POSW: state_d = (i_q == 2'd2) ? S_FIN : S_POS;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_q[0] <= RST_ANCHOR_X;
			anc_q[1] <= RST_ANCHOR_Y;
			anc_q[2] <= RST_ANCHOR_Z;
			rest_q <= RST_REST;
			spring_q <= RST_SPRING;
			damp_q <= RST_DAMPING;
			mass_q <= RST_MASS;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ANCHOR_X: anc_q[0] <= pwdata;
				REG_ANCHOR_Y: anc_q[1] <= pwdata;
				REG_ANCHOR_Z: anc_q[2] <= pwdata;
				REG_REST:     rest_q <= pwdata[30:0];
				REG_SPRING:   spring_q <= pwdata[30:0];
				REG_DAMPING:  damp_q <= pwdata[30:0];
				REG_MASS:     mass_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
				vel_q[k] <= '0;
				acc_q[k] <= '0;
			end
			running_q <= 1'b0;
			sat_q <= 1'b0;
			i_q <= '0;
			cnt_q <= '0;
			ret_q <= S_IDLE;
			rv_q <= 1'b0;
		end else begin
			if (div_start) begin
				dn_q <= div_num[63] ? 64'(-div_num) : 64'(div_num);
				dneg_q <= div_num[63];
				dden_q <= div_den;
				drem_q <= '0;
				cnt_q <= '0;
			end
			if (state_q == S_FIN && out_free) rv_q <= 1'b1;
			else if (result.ready) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						sat_q <= 1'b0;
						i_q <= '0;
						if (item.func) begin
							pos_q[0] <= item.start_x;
							pos_q[1] <= item.start_y;
							pos_q[2] <= item.start_z;
							for (int k = 0; k < 3; k++) begin
								vel_q[k] <= '0;
								acc_q[k] <= '0;
							end
							running_q <= 1'b1;
						end
					end
				end
				S_DIFF: begin
					d_q[i_q] <= sat32(diff_v);
					if (ovf32(diff_v)) sat_q <= 1'b1;
					i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
					sum_q <= '0;
				end
				S_SQ: prod_q <= mul_p[63:0];
				S_SQACC: begin
					sum_q <= sum_q + prod_q;
					if (i_q == 2'd2) begin
						i_q <= '0;
						x_q <= sum_q + prod_q;
						srem_q <= '0;
						root_q <= '0;
						cnt_q <= '0;
					end else begin
						i_q <= i_q + 2'd1;
					end
				end
				S_SQRT: begin
					x_q <= {x_q[61:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (srem_n >= strial) begin
						srem_q <= 34'(srem_n - strial);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						srem_q <= srem_n[33:0];
						root_q <= {root_q[30:0], 1'b0};
					end
				end
				S_MOFF: prod_q <= mul_p[63:0];
				S_DOFF: ret_q <= S_DISP;
				S_DIV: begin
					if (!div_start) begin
						dn_q <= {dn_q[62:0], dbit};
						drem_q <= dbit ? 32'(drem_n - {1'b0, dden_q}) : drem_n[31:0];
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_DISP: begin
					disp_q <= sat32(disp_v);
					if (ovf32(disp_v)) sat_q <= 1'b1;
				end
				S_MK: prod_q <= mul_p[63:0];
				S_FS: f_q <= -prod_tr;
				S_MC: prod_q <= mul_p[63:0];
				S_FD: begin
					if (ovf32(force_v)) sat_q <= 1'b1;
					ret_q <= S_ACC;
				end
				S_ACC: begin
					acc_q[i_q] <= sat32(65'(quot));
					if (ovf32(65'(quot))) sat_q <= 1'b1;
					i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
				end
				S_VEL: begin
					prod_q <= mul_p[63:0];
					dneg_q <= acc_q[i_q][31];
				end
				S_VELW: begin
					vel_q[i_q] <= sat32(vnew_v);
					if (ovf32(vnew_v)) sat_q <= 1'b1;
					i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
				end
				S_POS: begin
					prod_q <= mul_p[63:0];
					dneg_q <= vel_q[i_q][31];
				end
				S_POSW: begin
					pos_q[i_q] <= sat32(pnew_v);
					if (ovf32(pnew_v)) sat_q <= 1'b1;
					i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
				end
				S_FIN: begin
					if (out_free) begin
						result.pos_x <= pos_q[0];
						result.pos_y <= pos_q[1];
						result.pos_z <= pos_q[2];
						result.moving <= running_q;
						result.saturated <= sat_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid = rv_q;

	`DSM_ASSERT_NEXT(a_one_at_a_time, item.valid && item.ready, !item.ready, "request overlap")
	`DSM_ASSERT_NEXT(a_fin_delivers, state_q == S_FIN && out_free, result.valid, "result lost")
	`DSM_ASSERT_HOLDS(a_idle_no_sat, !(result.valid && !result.moving && result.saturated),
		"clip flagged while stopped")
endmodule

>>> bench/damped_spring_mass_gravity_step_unit_tb.sv
// Self-checking testbench of the damped spring-mass step unit: directed and random requests
// under several register settings, with an in-bench predictor of the tick arithmetic.
// Depends on dsm_pkg, the channel interfaces in dsm_if.sv and the top level.
`timescale 1ns / 100ps
module damped_spring_mass_gravity_step_unit_tb;
	import dsm_pkg::*;

	localparam longint ONE_Q = 64'sd65536;
	localparam longint GRAVITY_Q = 64'sd642253;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 40000000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic moving;
		logic saturated;
	} ball_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	dsm_item_if item_ch();
	dsm_result_if res_ch();

	damped_spring_mass_gravity_step_unit DUT (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state and register copies.
	logic signed [31:0] anchor [3];
	logic [30:0] rest_len, stiffness, damp_coef, mass_reg;
	logic signed [31:0] ball_pos [3], ball_vel [3], ball_acc [3];
	bit running;
	bit clip_seen;

	ball_state_t expected_positions [$];
	int errors = 0;
	longint cycles = 0;
	int requests_sent = 0, restarts_sent = 0, saturated_seen = 0, settings_used = 0;
	int stall_requests = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clip32(longint v);
		if (v > S32_MAX) begin
			clip_seen = 1'b1;
			return S32_MAX;
		end
		if (v < S32_MIN) begin
			clip_seen = 1'b1;
			return S32_MIN;
		end
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic void advance_tick();
		longint d [3];
		longint unsigned sumsq = 0;
		longint unsigned len;
		longint m, off, disp, fs, fd, f, v;
		for (int i = 0; i < 3; i++) begin
			d[i] = clip32(longint'(ball_pos[i]) - longint'(anchor[i]));
			sumsq += longint'(d[i] * d[i]);
		end
		len = int_sqrt(sumsq);
		if (len != 0) begin
			m = (mass_reg == 0) ? 64'sd1 : longint'({33'd0, mass_reg});
			for (int i = 0; i < 3; i++) begin
				off = (d[i] * longint'({33'd0, rest_len})) / longint'(len);
				disp = clip32(d[i] - off);
				fs = (-(longint'({33'd0, stiffness}) * disp)) / ONE_Q;
				fd = (-(longint'({33'd0, damp_coef}) * longint'(ball_vel[i]))) / ONE_Q;
				f = fs + fd;
				if (i == 1) f -= GRAVITY_Q;
				f = clip32(f);
				ball_acc[i] = 32'(clip32((f * ONE_Q) / m));
			end
		end
		for (int i = 0; i < 3; i++) begin
			v = longint'(ball_vel[i]) + longint'(ball_acc[i]) / 60;
			ball_vel[i] = 32'(clip32(v));
		end
		for (int i = 0; i < 3; i++) begin
			v = longint'(ball_pos[i]) + longint'(ball_vel[i]) / 60;
			ball_pos[i] = 32'(clip32(v));
		end
	endfunction

	function automatic ball_state_t predict_position(logic f, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		ball_state_t r;
		clip_seen = 1'b0;
		if (f) begin
			ball_pos[0] = x;
			ball_pos[1] = y;
			ball_pos[2] = z;
			for (int i = 0; i < 3; i++) begin
				ball_vel[i] = 0;
				ball_acc[i] = 0;
			end
			running = 1'b1;
		end
		if (running) advance_tick();
		r.x = ball_pos[0];
		r.y = ball_pos[1];
		r.z = ball_pos[2];
		r.moving = running;
		r.saturated = clip_seen;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Result side: random ready with short and long pauses, plus requested long hold-offs.
	int hold_left = 0, pause_left = 0, stalls_seen = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
			pause_left <= 0;
		end else if (stall_requests != stalls_seen) begin
			stalls_seen <= stall_requests;
			hold_left <= 4000;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (pause_left > 0) begin
			pause_left <= pause_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 99))
				0, 1, 2, 3, 4, 5: pause_left <= $urandom_range(1, 3);
				6: pause_left <= $urandom_range(50, 1200);
				default: pause_left <= 0;
			endcase
			res_ch.ready <= ($urandom_range(0, 9) < 8);
		end
	end

	always @(posedge clk) begin
		ball_state_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (res_ch.saturated) saturated_seen++;
			if (expected_positions.size() == 0) begin
				report_mismatch("result count", 1, 0);
			end else begin
				want = expected_positions.pop_front();
				if (res_ch.pos_x !== want.x) report_mismatch("pos_x", res_ch.pos_x, want.x);
				if (res_ch.pos_y !== want.y) report_mismatch("pos_y", res_ch.pos_y, want.y);
				if (res_ch.pos_z !== want.z) report_mismatch("pos_z", res_ch.pos_z, want.z);
				if (res_ch.moving !== want.moving)
					report_mismatch("moving", res_ch.moving, want.moving);
				if (res_ch.saturated !== want.saturated)
					report_mismatch("saturated", res_ch.saturated, want.saturated);
			end
		end
	end

	task automatic send_request(logic f, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		int gap;
		case ($urandom_range(0, 19))
			0: gap = $urandom_range(100, 900);
			1, 2, 3: gap = $urandom_range(1, 6);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.start_x <= x;
		item_ch.start_y <= y;
		item_ch.start_z <= z;
		do @(posedge clk); while (!item_ch.ready);
		expected_positions.push_back(predict_position(f, x, y, z));
		requests_sent++;
		if (f) restarts_sent++;
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ANCHOR_X: anchor[0] = value;
			REG_ANCHOR_Y: anchor[1] = value;
			REG_ANCHOR_Z: anchor[2] = value;
			REG_REST: rest_len = value[30:0];
			REG_SPRING: stiffness = value[30:0];
			REG_DAMPING: damp_coef = value[30:0];
			REG_MASS: mass_reg = value[30:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] rl, logic [31:0] k, logic [31:0] c, logic [31:0] m);
		drain_results();
		write_register(REG_ANCHOR_X, ax);
		write_register(REG_ANCHOR_Y, ay);
		write_register(REG_ANCHOR_Z, az);
		write_register(REG_REST, rl);
		write_register(REG_SPRING, k);
		write_register(REG_DAMPING, c);
		write_register(REG_MASS, m);
		settings_used++;
	endtask

	function automatic logic [31:0] pick_coord(logic [31:0] centre);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom();
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			4: return centre;
			default: return centre + 32'($signed($urandom_range(0, 262143)) - 131072);
		endcase
	endfunction

	task automatic random_motion(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 24) == 0 || !running)
				send_request(1'b1, pick_coord(anchor[0]), pick_coord(anchor[1]),
					pick_coord(anchor[2]));
			else
				send_request(1'b0, $urandom(), $urandom(), $urandom());
		end
	endtask

	task automatic test_directed();
		send_request(1'b0, 32'h7fffffff, 32'h80000000, 32'h12345678);
		send_request(1'b0, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_request(1'b1, 32'sd0, 32'sd0, 32'sd0);
		send_request(1'b0, 32'h0, 32'h0, 32'h0);
		send_request(1'b0, 32'h0, 32'h0, 32'h0);
		send_request(1'b1, anchor[0], anchor[1], anchor[2]);
		send_request(1'b0, 32'h0, 32'h0, 32'h0);
		send_request(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(1'b0, 32'h0, 32'h0, 32'h0);
		send_request(1'b1, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(1'b0, 32'h0, 32'h0, 32'h0);
		send_request(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_request(1'b1, 32'sd65536, 32'sd0, 32'sd0);
		for (int n = 0; n < 5; n++) send_request(1'b0, 32'hffffffff, 32'h0, 32'hffffffff);
	endtask

	task automatic test_default_setting();
		random_motion(475);
	endtask

	task automatic test_extreme_settings();
		apply_setting(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'd1);
		test_directed();
		random_motion(80);
		apply_setting(32'h80000000, 32'h7fffffff, 32'h80000000, 32'd0, 32'd0, 32'd0,
			32'h7fffffff);
		test_directed();
		random_motion(80);
		apply_setting(32'd0, 32'd0, 32'd0, 32'h7fffffff, 32'h7fffffff, 32'd0, 32'd0);
		send_request(1'b1, 32'd0, 32'd0, 32'd0);
		random_motion(80);
	endtask

	task automatic test_random_settings();
		for (int s = 0; s < 7; s++) begin
			apply_setting($urandom(), $urandom(), $urandom(), $urandom_range(0, 262144),
				$urandom(), $urandom_range(0, 1048576), $urandom_range(1, 1048576));
			random_motion(90);
		end
	endtask

	task automatic test_result_hold_off();
		apply_setting(32'd0, 32'sd65536, 32'd0, 32'd45875, 32'd6553600, 32'd131072,
			32'd131072);
		send_request(1'b1, 32'sd65536, 32'sd0, 32'sd32768);
		stall_requests++;
		random_motion(150);
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.func = 1'b0;
		item_ch.start_x = '0;
		item_ch.start_y = '0;
		item_ch.start_z = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		anchor[0] = RST_ANCHOR_X;
		anchor[1] = RST_ANCHOR_Y;
		anchor[2] = RST_ANCHOR_Z;
		rest_len = RST_REST;
		stiffness = RST_SPRING;
		damp_coef = RST_DAMPING;
		mass_reg = RST_MASS;
		for (int i = 0; i < 3; i++) begin
			ball_pos[i] = 0;
			ball_vel[i] = 0;
			ball_acc[i] = 0;
		end
		running = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_default_setting();
		test_extreme_settings();
		test_random_settings();
		test_result_hold_off();
		drain_results();
		repeat (1000) @(posedge clk);
		$display("Covered %0d requests (%0d restarts) over %0d register settings.",
			requests_sent, restarts_sent, settings_used + 1);
		$display("%0d results reported clipping; one long result hold-off applied.",
			saturated_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
